/* rtl/skt_pkg.sv */
// Shared types and constants for the sorted key table.
// Used by skt_ctrl, skt_datapath and sorted_key_table_core; depends on nothing.
package skt_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 3;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR     = 3'd0,
        OP_INSERT    = 3'd1,
        OP_DELETE    = 3'd2,
        OP_UPDATE    = 3'd3,
        OP_LOOKUP    = 3'd4,
        OP_REWIND    = 3'd5,
        OP_READ_NEXT = 3'd6
    } op_e;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_END       = 3'd4
    } status_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT,
        S_RD_NEXT,
        S_EMIT
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_CLEAR,
        CMD_REWIND,
        CMD_SRCH_INIT,
        CMD_SRCH_READ,
        CMD_SRCH_CMP,
        CMD_SET_STATUS,
        CMD_SHIFT_UP_INIT,
        CMD_SHIFT_DN_INIT,
        CMD_SHIFT_STEP,
        CMD_INS_WRITE,
        CMD_DEL_FINISH,
        CMD_UPD_WRITE,
        CMD_LOOKUP_HIT,
        CMD_CUR_READ,
        CMD_CUR_HIT,
        CMD_CUR_END,
        CMD_EMIT
    } cmd_e;

    typedef struct packed {
        cmd_e    cmd;
        status_e status;
    } dp_ctrl_t;

    typedef struct packed {
        op_e  op;
        logic srch_open;
        logic key_eq;
        logic table_full;
        logic shift_idle;
        logic cur_valid;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/sorted_key_table_core.sv */
// Top level of the sorted key table: sequencer plus datapath.
// Depends on skt_pkg, skt_ctrl and skt_datapath.
//
//   channel | dir | handshake          | beat fields
//   s_      | in  | s_valid / s_ready  | s_op, s_key, s_payload
//   m_      | out | m_valid / m_ready  | m_status, m_found_key, m_found_payload,
//           |     |                    | m_position, m_count
//
// One beat is processed at a time. A search makes at most log2(DEPTH)+1 probes,
// each a memory read and a compare. Delete and insert then shift the entries
// behind the hit or insert point, through the single memory port pair that moves
// one entry per cycle. An insert that goes ahead always ends its search in a miss.
// Synchronous active-low reset empties the table and rewinds the cursor; no
// memory clear pass is needed. A new beat is taken while a result waits in the
// output register; the next result then holds until that one is taken.
module sorted_key_table_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [skt_pkg::OP_W-1:0]     s_op,
    input  logic [skt_pkg::KEY_W-1:0]    s_key,
    input  logic [skt_pkg::DATA_W-1:0]   s_payload,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [skt_pkg::STAT_W-1:0]   m_status,
    output logic [skt_pkg::KEY_W-1:0]    m_found_key,
    output logic [skt_pkg::DATA_W-1:0]   m_found_payload,
    output logic [skt_pkg::POS_W-1:0]    m_position,
    output logic [skt_pkg::COUNT_W-1:0]  m_count
);

    skt_pkg::dp_ctrl_t ctrl;
    skt_pkg::dp_stat_t stat;

    skt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    skt_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_op            (s_op),
        .s_key           (s_key),
        .s_payload       (s_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found_key     (m_found_key),
        .m_found_payload (m_found_payload),
        .m_position      (m_position),
        .m_count         (m_count),
        .ctrl            (ctrl),
        .stat            (stat)
    );

endmodule

/* rtl/skt_ctrl.sv */
// Sequencer for the sorted key table: one operation at a time.
// Depends on skt_pkg; drives skt_datapath through dp_ctrl_t, reads dp_stat_t.
module skt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  skt_pkg::dp_stat_t stat,
    output skt_pkg::dp_ctrl_t ctrl
);

    skt_pkg::state_t state_reg;
    skt_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skt_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            skt_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = skt_pkg::S_DECODE;
                end
            end
            skt_pkg::S_DECODE: begin
                case (stat.op)
                    skt_pkg::OP_INSERT, skt_pkg::OP_DELETE,
                    skt_pkg::OP_UPDATE, skt_pkg::OP_LOOKUP: begin
                        state_next = skt_pkg::S_SRCH_RD;
                    end
                    skt_pkg::OP_READ_NEXT: begin
                        state_next = stat.cur_valid ? skt_pkg::S_RD_NEXT : skt_pkg::S_EMIT;
                    end
                    default: begin
                        state_next = skt_pkg::S_EMIT;
                    end
                endcase
            end
            skt_pkg::S_SRCH_RD: begin
                if (stat.srch_open) begin
                    state_next = skt_pkg::S_SRCH_CMP;
                end else if (stat.op == skt_pkg::OP_INSERT && !stat.table_full) begin
                    state_next = skt_pkg::S_SHIFT;
                end else begin
                    state_next = skt_pkg::S_EMIT;
                end
            end
            skt_pkg::S_SRCH_CMP: begin
                if (!stat.key_eq) begin
                    state_next = skt_pkg::S_SRCH_RD;
                end else if (stat.op == skt_pkg::OP_DELETE) begin
                    state_next = skt_pkg::S_SHIFT;
                end else begin
                    state_next = skt_pkg::S_EMIT;
                end
            end
            skt_pkg::S_SHIFT: begin
                if (stat.shift_idle) begin
                    state_next = skt_pkg::S_EMIT;
                end
            end
            skt_pkg::S_RD_NEXT: begin
                state_next = skt_pkg::S_EMIT;
            end
            skt_pkg::S_EMIT: begin
                if (stat.out_free) begin
                    state_next = skt_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        ctrl.cmd    = skt_pkg::CMD_NONE;
        ctrl.status = skt_pkg::ST_OK;
        s_ready     = 1'b0;
        case (state_reg)
            skt_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.cmd = skt_pkg::CMD_CAPTURE;
                end
            end
            skt_pkg::S_DECODE: begin
                case (stat.op)
                    skt_pkg::OP_CLEAR: begin
                        ctrl.cmd = skt_pkg::CMD_CLEAR;
                    end
                    skt_pkg::OP_INSERT, skt_pkg::OP_DELETE,
                    skt_pkg::OP_UPDATE, skt_pkg::OP_LOOKUP: begin
                        ctrl.cmd = skt_pkg::CMD_SRCH_INIT;
                    end
                    skt_pkg::OP_REWIND: begin
                        ctrl.cmd = skt_pkg::CMD_REWIND;
                    end
                    skt_pkg::OP_READ_NEXT: begin
                        ctrl.cmd = stat.cur_valid ? skt_pkg::CMD_CUR_READ : skt_pkg::CMD_CUR_END;
                    end
                    default: begin
                        ctrl.cmd = skt_pkg::CMD_NONE;
                    end
                endcase
            end
            skt_pkg::S_SRCH_RD: begin
                if (stat.srch_open) begin
                    ctrl.cmd = skt_pkg::CMD_SRCH_READ;
                end else if (stat.op == skt_pkg::OP_INSERT) begin
                    if (stat.table_full) begin
                        ctrl.cmd    = skt_pkg::CMD_SET_STATUS;
                        ctrl.status = skt_pkg::ST_FULL;
                    end else begin
                        ctrl.cmd = skt_pkg::CMD_SHIFT_UP_INIT;
                    end
                end else begin
                    ctrl.cmd    = skt_pkg::CMD_SET_STATUS;
                    ctrl.status = skt_pkg::ST_NOT_FOUND;
                end
            end
            skt_pkg::S_SRCH_CMP: begin
                if (!stat.key_eq) begin
                    ctrl.cmd = skt_pkg::CMD_SRCH_CMP;
                end else begin
                    case (stat.op)
                        skt_pkg::OP_INSERT: begin
                            ctrl.cmd    = skt_pkg::CMD_SET_STATUS;
                            ctrl.status = skt_pkg::ST_DUPLICATE;
                        end
                        skt_pkg::OP_DELETE: begin
                            ctrl.cmd = skt_pkg::CMD_SHIFT_DN_INIT;
                        end
                        skt_pkg::OP_UPDATE: begin
                            ctrl.cmd = skt_pkg::CMD_UPD_WRITE;
                        end
                        default: begin
                            ctrl.cmd = skt_pkg::CMD_LOOKUP_HIT;
                        end
                    endcase
                end
            end
            skt_pkg::S_SHIFT: begin
                if (!stat.shift_idle) begin
                    ctrl.cmd = skt_pkg::CMD_SHIFT_STEP;
                end else if (stat.op == skt_pkg::OP_INSERT) begin
                    ctrl.cmd = skt_pkg::CMD_INS_WRITE;
                end else begin
                    ctrl.cmd = skt_pkg::CMD_DEL_FINISH;
                end
            end
            skt_pkg::S_RD_NEXT: begin
                ctrl.cmd = skt_pkg::CMD_CUR_HIT;
            end
            skt_pkg::S_EMIT: begin
                if (stat.out_free) begin
                    ctrl.cmd = skt_pkg::CMD_EMIT;
                end
            end
            default: begin
                ctrl.cmd = skt_pkg::CMD_NONE;
            end
        endcase
    end

endmodule

/* rtl/skt_datapath.sv */
// Datapath of the sorted key table: key and payload memories, search bounds,
// shift engine, count, read cursor and the result register. Depends on skt_pkg.
module skt_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [skt_pkg::OP_W-1:0]     s_op,
    input  logic [skt_pkg::KEY_W-1:0]    s_key,
    input  logic [skt_pkg::DATA_W-1:0]   s_payload,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [skt_pkg::STAT_W-1:0]   m_status,
    output logic [skt_pkg::KEY_W-1:0]    m_found_key,
    output logic [skt_pkg::DATA_W-1:0]   m_found_payload,
    output logic [skt_pkg::POS_W-1:0]    m_position,
    output logic [skt_pkg::COUNT_W-1:0]  m_count,
    input  skt_pkg::dp_ctrl_t            ctrl,
    output skt_pkg::dp_stat_t            stat
);

    localparam int AW = skt_pkg::ADDR_W;
    localparam int CW = skt_pkg::CNT_W;

    logic [skt_pkg::KEY_W-1:0]  key_mem [skt_pkg::DEPTH];
    logic [skt_pkg::DATA_W-1:0] pay_mem [skt_pkg::DEPTH];

    logic [skt_pkg::KEY_W-1:0]  krd_reg;
    logic [skt_pkg::DATA_W-1:0] prd_reg;

    // captured beat
    logic [skt_pkg::OP_W-1:0]   op_reg;
    logic [skt_pkg::KEY_W-1:0]  key_reg;
    logic [skt_pkg::DATA_W-1:0] pay_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [AW-1:0] mid_reg, mid_next;

    // shift engine
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] at_reg, at_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic          up_reg, up_next;
    logic          more_reg, more_next;
    logic          pend_reg, pend_next;

    // result being built
    skt_pkg::status_e           res_status_reg, res_status_next;
    logic [skt_pkg::KEY_W-1:0]  res_key_reg, res_key_next;
    logic [skt_pkg::DATA_W-1:0] res_pay_reg, res_pay_next;
    logic [CW-1:0]              res_pos_reg, res_pos_next;

    logic                         m_valid_reg, m_valid_next;
    logic [skt_pkg::STAT_W-1:0]   m_status_reg;
    logic [skt_pkg::KEY_W-1:0]    m_key_reg;
    logic [skt_pkg::DATA_W-1:0]   m_pay_reg;
    logic [skt_pkg::POS_W-1:0]    m_pos_reg;
    logic [skt_pkg::COUNT_W-1:0]  m_count_reg;

    // memory port signals
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       kwe, pwe;
    logic [AW-1:0]              wr_addr;
    logic [skt_pkg::KEY_W-1:0]  kwd;
    logic [skt_pkg::DATA_W-1:0] pwd;

    logic [CW:0]   lo_hi_sum;
    logic [AW-1:0] mid_calc;
    logic [CW:0]   idx_plus2;
    logic          key_lt;

    assign lo_hi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc  = lo_hi_sum[AW:1];
    assign idx_plus2 = {1'b0, idx_reg} + (CW+1)'(2);
    assign key_lt    = key_reg < krd_reg;

    assign stat.op         = skt_pkg::op_e'(op_reg);
    assign stat.srch_open  = lo_reg < hi_reg;
    assign stat.key_eq     = key_reg == krd_reg;
    assign stat.table_full = count_reg >= CW'(skt_pkg::DEPTH);
    assign stat.shift_idle = !more_reg && !pend_reg;
    assign stat.cur_valid  = cursor_reg < count_reg;
    assign stat.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            krd_reg <= key_mem[rd_addr];
            prd_reg <= pay_mem[rd_addr];
        end
        if (kwe) begin
            key_mem[wr_addr] <= kwd;
        end
        if (pwe) begin
            pay_mem[wr_addr] <= pwd;
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = mid_calc;
        kwe     = 1'b0;
        pwe     = 1'b0;
        wr_addr = dst_reg;
        kwd     = krd_reg;
        pwd     = prd_reg;
        case (ctrl.cmd)
            skt_pkg::CMD_SRCH_READ: begin
                rd_en = 1'b1;
            end
            skt_pkg::CMD_CUR_READ: begin
                rd_en   = 1'b1;
                rd_addr = cursor_reg[AW-1:0];
            end
            skt_pkg::CMD_SHIFT_STEP: begin
                // read the next source while writing the one fetched last cycle
                rd_en   = more_reg;
                rd_addr = up_reg ? AW'(idx_reg - CW'(1)) : AW'(idx_reg + CW'(1));
                kwe     = pend_reg;
                pwe     = pend_reg;
            end
            skt_pkg::CMD_INS_WRITE: begin
                kwe     = 1'b1;
                pwe     = 1'b1;
                wr_addr = at_reg[AW-1:0];
                kwd     = key_reg;
                pwd     = pay_reg;
            end
            skt_pkg::CMD_UPD_WRITE: begin
                pwe     = 1'b1;
                wr_addr = mid_reg;
                pwd     = pay_reg;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        at_next         = at_reg;
        dst_next        = dst_reg;
        up_next         = up_reg;
        more_next       = more_reg;
        pend_next       = pend_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_pay_next    = res_pay_reg;
        res_pos_next    = res_pos_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        case (ctrl.cmd)
            skt_pkg::CMD_CAPTURE: begin
                res_status_next = skt_pkg::ST_OK;
                res_key_next    = '0;
                res_pay_next    = '0;
                res_pos_next    = '0;
            end
            skt_pkg::CMD_CLEAR: begin
                count_next  = '0;
                cursor_next = '0;
            end
            skt_pkg::CMD_REWIND: begin
                cursor_next = '0;
            end
            skt_pkg::CMD_SRCH_INIT: begin
                lo_next = '0;
                hi_next = count_reg;
            end
            skt_pkg::CMD_SRCH_READ: begin
                mid_next = mid_calc;
            end
            skt_pkg::CMD_SRCH_CMP: begin
                if (key_lt) begin
                    hi_next = CW'(mid_reg);
                end else begin
                    lo_next = CW'(mid_reg) + CW'(1);
                end
            end
            skt_pkg::CMD_SET_STATUS: begin
                res_status_next = ctrl.status;
            end
            skt_pkg::CMD_SHIFT_UP_INIT: begin
                // destinations run from count down to the insert point plus one
                at_next   = lo_reg;
                idx_next  = count_reg;
                up_next   = 1'b1;
                more_next = count_reg > lo_reg;
                pend_next = 1'b0;
            end
            skt_pkg::CMD_SHIFT_DN_INIT: begin
                // destinations run from the hit up to count minus two
                at_next   = CW'(mid_reg);
                idx_next  = CW'(mid_reg);
                up_next   = 1'b0;
                more_next = (CW'(mid_reg) + CW'(1)) < count_reg;
                pend_next = 1'b0;
            end
            skt_pkg::CMD_SHIFT_STEP: begin
                pend_next = more_reg;
                if (more_reg) begin
                    dst_next = idx_reg[AW-1:0];
                    if (up_reg) begin
                        idx_next  = idx_reg - CW'(1);
                        more_next = (idx_reg - CW'(1)) > at_reg;
                    end else begin
                        idx_next  = idx_reg + CW'(1);
                        more_next = idx_plus2 < {1'b0, count_reg};
                    end
                end
            end
            skt_pkg::CMD_INS_WRITE: begin
                count_next   = count_reg + CW'(1);
                res_pos_next = at_reg;
            end
            skt_pkg::CMD_DEL_FINISH: begin
                count_next   = count_reg - CW'(1);
                res_pos_next = at_reg;
            end
            skt_pkg::CMD_UPD_WRITE: begin
                res_pos_next = CW'(mid_reg);
            end
            skt_pkg::CMD_LOOKUP_HIT: begin
                res_key_next = krd_reg;
                res_pay_next = prd_reg;
                res_pos_next = CW'(mid_reg);
            end
            skt_pkg::CMD_CUR_HIT: begin
                res_key_next = krd_reg;
                res_pay_next = prd_reg;
                res_pos_next = cursor_reg;
                cursor_next  = cursor_reg + CW'(1);
            end
            skt_pkg::CMD_CUR_END: begin
                res_status_next = skt_pkg::ST_END;
                cursor_next     = count_reg;
            end
            skt_pkg::CMD_EMIT: begin
                m_valid_next = 1'b1;
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            cursor_reg  <= '0;
            more_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            more_reg    <= more_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.cmd == skt_pkg::CMD_CAPTURE) begin
            op_reg  <= s_op;
            key_reg <= s_key;
            pay_reg <= s_payload;
        end
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        idx_reg        <= idx_next;
        at_reg         <= at_next;
        dst_reg        <= dst_next;
        up_reg         <= up_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_pay_reg    <= res_pay_next;
        res_pos_reg    <= res_pos_next;
        if (ctrl.cmd == skt_pkg::CMD_EMIT) begin
            m_status_reg <= res_status_reg;
            m_key_reg    <= res_key_reg;
            m_pay_reg    <= res_pay_reg;
            m_pos_reg    <= res_pos_reg[skt_pkg::POS_W-1:0];
            m_count_reg  <= skt_pkg::COUNT_W'(count_reg);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_found_key     = m_key_reg;
    assign m_found_payload = m_pay_reg;
    assign m_position      = m_pos_reg;
    assign m_count         = m_count_reg;

endmodule

/* tb/sv/skt_reply_check.sv */
// Result checker for sorted_key_table_core: mirrors the sorted table, predicts one reply
// per command beat and compares every result beat field by field.
// Depends on skt_pkg for widths, depth and op/status codes.
module skt_reply_check
    import skt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [OP_W-1:0]     s_op,
    input  logic [KEY_W-1:0]    s_key,
    input  logic [DATA_W-1:0]   s_payload,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [STAT_W-1:0]   m_status,
    input  logic [KEY_W-1:0]    m_found_key,
    input  logic [DATA_W-1:0]   m_found_payload,
    input  logic [POS_W-1:0]    m_position,
    input  logic [COUNT_W-1:0]  m_count,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [KEY_W-1:0]   found_key;
        logic [DATA_W-1:0]  found_payload;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
    } table_reply_t;

    logic [KEY_W-1:0]  key_tab [DEPTH];
    logic [DATA_W-1:0] data_tab [DEPTH];
    int unsigned       n_rec;
    int unsigned       cursor;
    table_reply_t      replies [$];
    table_reply_t      want;
    int                errs = 0;

    // Binary search over the live records; on a miss, at is the insertion slot.
    function automatic bit locate(input logic [KEY_W-1:0] key, output int unsigned at);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = n_rec;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (key < key_tab[mid]) begin
                hi = mid;
            end else if (key > key_tab[mid]) begin
                lo = mid + 1;
            end else begin
                at = mid;
                return 1'b1;
            end
        end
        at = lo;
        return 1'b0;
    endfunction

    function automatic table_reply_t run_command(input logic [OP_W-1:0] op,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [DATA_W-1:0] data);
        table_reply_t r;
        int unsigned  at;
        bit           hit;
        r = '0;
        at = 0;
        hit = 1'b0;
        if (op inside {OP_INSERT, OP_DELETE, OP_UPDATE, OP_LOOKUP})
            hit = locate(key, at);
        case (op)
            OP_CLEAR: begin
                n_rec = 0;
                cursor = 0;
            end
            OP_INSERT: begin
                if (hit) begin
                    r.status = ST_DUPLICATE;
                end else if (n_rec >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int unsigned i = n_rec; i > at; i--) begin
                        key_tab[i] = key_tab[i-1];
                        data_tab[i] = data_tab[i-1];
                    end
                    key_tab[at] = key;
                    data_tab[at] = data;
                    n_rec++;
                    r.position = at[POS_W-1:0];
                end
            end
            OP_DELETE: begin
                if (hit) begin
                    for (int unsigned i = at; i + 1 < n_rec; i++) begin
                        key_tab[i] = key_tab[i+1];
                        data_tab[i] = data_tab[i+1];
                    end
                    n_rec--;
                    r.position = at[POS_W-1:0];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_UPDATE: begin
                if (hit) begin
                    data_tab[at] = data;
                    r.position = at[POS_W-1:0];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_LOOKUP: begin
                if (hit) begin
                    r.found_key = key_tab[at];
                    r.found_payload = data_tab[at];
                    r.position = at[POS_W-1:0];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_REWIND: begin
                cursor = 0;
            end
            OP_READ_NEXT: begin
                if (cursor < n_rec) begin
                    r.found_key = key_tab[cursor];
                    r.found_payload = data_tab[cursor];
                    r.position = cursor[POS_W-1:0];
                    cursor++;
                end else begin
                    r.status = ST_END;
                    cursor = n_rec;
                end
            end
            default: begin
            end
        endcase
        r.count = n_rec[COUNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            errs++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            n_rec = 0;
            cursor = 0;
            replies.delete();
        end else begin
            // Compare before pushing: a reply can never leave on the beat that caused it.
            if (m_valid && m_ready) begin
                if (replies.size() == 0) begin
                    $error("result beat with no command outstanding");
                    errs++;
                end else begin
                    want = replies.pop_front();
                    check_field("status", 64'(want.status), 64'(m_status));
                    check_field("found_key", 64'(want.found_key), 64'(m_found_key));
                    check_field("found_payload", 64'(want.found_payload),
                                64'(m_found_payload));
                    check_field("position", 64'(want.position), 64'(m_position));
                    check_field("count", 64'(want.count), 64'(m_count));
                end
            end
            if (s_valid && s_ready)
                replies.push_back(run_command(s_op, s_key, s_payload));
        end
        pending <= replies.size();
        fail_count <= errs;
    end

endmodule

/* tb/sv/tb.sv */
// Top of the sorted key table testbench: clock, reset, command stimulus and verdict.
// Depends on skt_pkg, sorted_key_table_core and skt_reply_check.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import skt_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int QUIET_LIMIT = 5000;
    localparam int ITEM_TARGET = 380;
    localparam int POOL_MAX    = 96;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op = '0;
    logic [KEY_W-1:0]    s_key = '0;
    logic [DATA_W-1:0]   s_payload = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STAT_W-1:0]   m_status;
    logic [KEY_W-1:0]    m_found_key;
    logic [DATA_W-1:0]   m_found_payload;
    logic [POS_W-1:0]    m_position;
    logic [COUNT_W-1:0]  m_count;

    int fail_count;
    int pending;
    int quiet = 0;
    int beats_sent = 0;
    bit s_idle_on = 1'b1;
    bit m_idle_on = 1'b1;
    logic [KEY_W-1:0] key_pool [POOL_MAX];
    int pool_size = 1;

    sorted_key_table_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_op(s_op), .s_key(s_key), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_found_key(m_found_key),
        .m_found_payload(m_found_payload), .m_position(m_position), .m_count(m_count)
    );

    skt_reply_check chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_op(s_op), .s_key(s_key), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_found_key(m_found_key),
        .m_found_payload(m_found_payload), .m_position(m_position), .m_count(m_count),
        .fail_count(fail_count), .pending(pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= m_idle_on ? ($urandom_range(0, 99) >= 27) : 1'b1;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Call at a rising edge; returns at the edge that accepts the beat.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                             input logic [DATA_W-1:0] data);
        while (s_idle_on && $urandom_range(0, 99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_key <= key;
        s_payload <= data;
        // Sample ready away from the active edge.
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        beats_sent++;
    endtask

    task automatic fill_pool(input int n);
        pool_size = n;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
                key_pool[i] = $urandom_range(0, 1) ? '1 : '0;
            else
                key_pool[i] = $urandom;
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return key_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    task automatic random_beat();
        int roll;
        logic [OP_W-1:0] op;
        roll = $urandom_range(0, 99);
        if (roll < 35)      op = OP_INSERT;
        else if (roll < 50) op = OP_DELETE;
        else if (roll < 60) op = OP_UPDATE;
        else if (roll < 75) op = OP_LOOKUP;
        else if (roll < 90) op = OP_READ_NEXT;
        else if (roll < 95) op = OP_REWIND;
        else if (roll < 98) op = OP_CLEAR;
        else                op = OP_UNUSED;
        send_beat(op, pick_key(), $urandom);
    endtask

    initial begin
        int round;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table: end of list and misses
        send_beat(OP_CLEAR, 32'h0, 32'h0);
        send_beat(OP_READ_NEXT, 32'h0, 32'hFFFF_FFFF);
        send_beat(OP_LOOKUP, 32'h5, 32'h0);
        send_beat(OP_DELETE, 32'h5, 32'h0);
        send_beat(OP_UPDATE, 32'h5, 32'h1234_5678);
        // extreme keys and payloads, a duplicate, then lookups and an update
        send_beat(OP_INSERT, 32'h0, 32'h0);
        send_beat(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
        send_beat(OP_INSERT, 32'h0, 32'h5555_5555);
        send_beat(OP_LOOKUP, 32'h0, 32'h0);
        send_beat(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_beat(OP_UPDATE, 32'h8000_0000, 32'h5A5A_5A5A);
        send_beat(OP_LOOKUP, 32'h8000_0000, 32'h0);
        // walk past the end, then delete under the cursor
        send_beat(OP_REWIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (4) send_beat(OP_READ_NEXT, 32'h0, 32'h0);
        send_beat(OP_DELETE, 32'h0, 32'h0);
        send_beat(OP_READ_NEXT, 32'h0, 32'h0);
        send_beat(OP_REWIND, 32'h0, 32'h0);
        send_beat(OP_READ_NEXT, 32'h0, 32'h0);
        send_beat(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(OP_DELETE, 32'hFFFF_FFFF, 32'h0);
        send_beat(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // fill past capacity, duplicate on a full table, full walk
        fill_pool(80);
        for (int i = 0; i < 80; i++) send_beat(OP_INSERT, key_pool[i], $urandom);
        send_beat(OP_INSERT, key_pool[3], $urandom);
        send_beat(OP_REWIND, $urandom, $urandom);
        for (int i = 0; i < DEPTH + 2; i++) send_beat(OP_READ_NEXT, $urandom, $urandom);
        repeat (40) random_beat();

        round = 0;
        while (beats_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 2) == 0)
                fill_pool(8);
            else
                fill_pool($urandom_range(0, 1) ? 24 : 90);
            // one round runs at full rate on both sides
            s_idle_on = (round != 1);
            m_idle_on = (round != 1);
            repeat ($urandom_range(30, 60)) random_beat();
            round++;
        end
        s_idle_on = 1'b1;
        m_idle_on = 1'b1;
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
